/* sv/rglu_pkg.sv */
`timescale 1ns / 1ps

package rglu_pkg;

    // magnitude width and derived widths
    localparam int MAG_W = 63;
    localparam int ADD_W = MAG_W + 1;
    localparam int CNT_W = 6;

    localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0] MAG_ZERO  = {MAG_W{1'b0}};
    localparam logic [MAG_W-1:0] MAG_ONE   = {{(MAG_W-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(MAG_W - 1);

    // operations of the shared datapath
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_G1,
        DP_LOAD_G2,
        DP_TAKE_B,
        DP_PREP,
        DP_GCD_STEP,
        DP_SHL_A,
        DP_LOAD_DIV,
        DP_DIV_STEP,
        DP_LOAD_MUL,
        DP_MUL_STEP
    } dp_op_t;

    // how the running lcm is updated
    typedef enum logic [1:0] {
        LCM_KEEP,
        LCM_ZERO,
        LCM_SAT,
        LCM_MUL
    } lcm_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD1,
        S_LOAD2,
        S_GCHK,
        S_GPREP,
        S_GRUN,
        S_GSHL,
        S_GEND,
        S_DIV,
        S_MUL_LOAD,
        S_MUL,
        S_MUL_END,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic k_zero;
        logic cnt_last;
        logic mul_ovf;
    } dp_stat_t;

    typedef struct packed {
        logic take;
        logic m_zero;
        logic lcm_zero;
        logic ovf;
        logic out_free;
    } acc_stat_t;

    typedef struct packed {
        dp_op_t  op;
        logic    busy;
        logic    wr_gcd;
        lcm_wr_t lcm_wr;
        logic    out_load;
    } seq_ctl_t;

endpackage

/* sv/rglu_dp.sv */
`timescale 1ns / 1ps

module rglu_dp
    import rglu_pkg::*;
(
    input  logic             clk,
    input  dp_op_t           op,
    input  logic [MAG_W-1:0] gcd_acc,
    input  logic [MAG_W-1:0] lcm_acc,
    input  logic [MAG_W-1:0] mag,
    output logic [MAG_W-1:0] result,
    output dp_stat_t         stat
);

    logic [MAG_W-1:0] a_reg, a_next;
    logic [MAG_W-1:0] b_reg, b_next;
    logic [MAG_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // the one shared adder / subtractor
    logic [ADD_W-1:0] add_a, add_b;
    logic             add_sub;
    logic [ADD_W:0]   add_sum;
    logic             carry;

    always_comb
    begin
        case (op)
            DP_DIV_STEP:
            begin
                add_a   = {r_reg, a_reg[MAG_W-1]};
                add_b   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            DP_MUL_STEP:
            begin
                add_a   = {1'b0, r_reg};
                add_b   = a_reg[0] ? {1'b0, b_reg} : {ADD_W{1'b0}};
                add_sub = 1'b0;
            end
            default:
            begin
                add_a   = {1'b0, b_reg};
                add_b   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                + {{ADD_W{1'b0}}, add_sub};
        carry   = add_sum[ADD_W];
    end

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        case (op)
            DP_LOAD_G1:
            begin
                a_next   = gcd_acc;
                b_next   = mag;
                cnt_next = '0;
            end
            DP_LOAD_G2:
            begin
                a_next   = lcm_acc;
                b_next   = mag;
                cnt_next = '0;
            end
            DP_TAKE_B:
                a_next = b_reg;
            DP_PREP:
            begin
                // strip common factors of two, then the rest from a
                a_next = a_reg >> 1;
                if (!b_reg[0])
                begin
                    b_next   = b_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DP_GCD_STEP:
            begin
                if (!b_reg[0])
                    b_next = b_reg >> 1;
                else if (!carry)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                    b_next = add_sum[MAG_W-1:0];
            end
            DP_SHL_A:
            begin
                a_next   = a_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
            DP_LOAD_DIV:
            begin
                b_next   = a_reg;
                a_next   = lcm_acc;
                r_next   = '0;
                cnt_next = '0;
            end
            DP_DIV_STEP:
            begin
                r_next   = carry ? add_sum[MAG_W-1:0] : {r_reg[MAG_W-2:0], a_reg[MAG_W-1]};
                a_next   = {a_reg[MAG_W-2:0], carry};
                cnt_next = cnt_reg + 1'b1;
            end
            DP_LOAD_MUL:
            begin
                b_next   = mag;
                r_next   = '0;
                cnt_next = '0;
            end
            DP_MUL_STEP:
            begin
                r_next   = add_sum[MAG_W:1];
                a_next   = {add_sum[0], a_reg[MAG_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign result        = a_reg;
    assign stat.a_zero   = (a_reg == MAG_ZERO);
    assign stat.b_zero   = (b_reg == MAG_ZERO);
    assign stat.a_odd    = a_reg[0];
    assign stat.k_zero   = (cnt_reg == '0);
    assign stat.cnt_last = (cnt_reg == STEP_LAST);
    // product upper half r must be clear to fit in 63 bits
    assign stat.mul_ovf  = (r_reg != MAG_ZERO);

endmodule

/* sv/rglu_seq.sv */
`timescale 1ns / 1ps

module rglu_seq
    import rglu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_stat_t  dstat,
    input  acc_stat_t astat,
    output seq_ctl_t  ctl
);

    seq_state_t state_reg, state_next;
    logic       pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        ctl.op       = DP_NOP;
        ctl.busy     = 1'b1;
        ctl.wr_gcd   = 1'b0;
        ctl.lcm_wr   = LCM_KEEP;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.busy = 1'b0;
                if (astat.take)
                    state_next = S_LOAD1;
            end
            S_LOAD1:
            begin
                ctl.op     = DP_LOAD_G1;
                pass_next  = 1'b0;
                state_next = S_GCHK;
            end
            S_LOAD2:
            begin
                ctl.op     = DP_LOAD_G2;
                pass_next  = 1'b1;
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                if (dstat.a_zero)
                begin
                    ctl.op     = DP_TAKE_B;
                    state_next = S_GEND;
                end
                else if (dstat.b_zero)
                    state_next = S_GEND;
                else
                    state_next = S_GPREP;
            end
            S_GPREP:
            begin
                if (dstat.a_odd)
                    state_next = S_GRUN;
                else
                    ctl.op = DP_PREP;
            end
            S_GRUN:
            begin
                if (dstat.b_zero)
                    state_next = S_GSHL;
                else
                    ctl.op = DP_GCD_STEP;
            end
            S_GSHL:
            begin
                if (dstat.k_zero)
                    state_next = S_GEND;
                else
                    ctl.op = DP_SHL_A;
            end
            S_GEND:
            begin
                if (pass_reg)
                begin
                    ctl.op     = DP_LOAD_DIV;
                    state_next = S_DIV;
                end
                else
                begin
                    ctl.wr_gcd = 1'b1;
                    if (astat.m_zero || astat.lcm_zero)
                    begin
                        ctl.lcm_wr = LCM_ZERO;
                        state_next = S_DONE;
                    end
                    else if (astat.ovf)
                    begin
                        ctl.lcm_wr = LCM_SAT;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_LOAD2;
                end
            end
            S_DIV:
            begin
                ctl.op = DP_DIV_STEP;
                if (dstat.cnt_last)
                    state_next = S_MUL_LOAD;
            end
            S_MUL_LOAD:
            begin
                ctl.op     = DP_LOAD_MUL;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.op = DP_MUL_STEP;
                if (dstat.cnt_last)
                    state_next = S_MUL_END;
            end
            S_MUL_END:
            begin
                ctl.lcm_wr = LCM_MUL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (astat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* sv/running_gcd_lcm_unit.sv */
`timescale 1ns / 1ps
// fast path: an item whose gcd settles at once (lcm zeroed or held) passes the load, check,
// end and done states; with a lcm update, two binary gcd runs plus 63 divide and 63 multiply
// steps, data-dependent, all on the one 64-bit adder
// throughput: one item at a time; the next item transfers once the result is registered
// reset (rst_n low, asynchronous): gcd 0, lcm 1, overflow clear, no result pending
module running_gcd_lcm_unit
    import rglu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [63:0]      operand,
    input  logic             first,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [MAG_W-1:0] gcd_value,
    output logic [MAG_W-1:0] lcm_value,
    output logic             lcm_overflow
);

    // running state of the list
    logic [MAG_W-1:0] gcd_acc_reg, gcd_acc_next;
    logic [MAG_W-1:0] lcm_acc_reg, lcm_acc_next;
    logic             ovf_reg, ovf_next;
    // magnitude of the item under work
    logic [MAG_W-1:0] mag_reg, mag_next;
    // output register, frees the engine while a result waits
    logic             result_valid_reg;
    logic [MAG_W-1:0] gcd_out_reg;
    logic [MAG_W-1:0] lcm_out_reg;
    logic             ovf_out_reg;

    logic [MAG_W-1:0] in_mag;
    logic [63:0]      neg_operand;
    logic             take;
    logic [MAG_W-1:0] dp_result;
    dp_stat_t         dstat;
    acc_stat_t        astat;
    seq_ctl_t         ctl;

    // magnitude of the operand, the most negative value clips to the top code
    always_comb
    begin
        neg_operand = ~operand + 64'd1;
        if (operand[63] && (operand[62:0] == '0))
            in_mag = MAG_MAX;
        else if (operand[63])
            in_mag = neg_operand[MAG_W-1:0];
        else
            in_mag = operand[MAG_W-1:0];
    end

    assign item_stall = ctl.busy;
    assign take       = item_valid && !item_stall;

    assign astat.take     = take;
    assign astat.m_zero   = (mag_reg == MAG_ZERO);
    assign astat.lcm_zero = (lcm_acc_reg == MAG_ZERO);
    assign astat.ovf      = ovf_reg;
    assign astat.out_free = !result_valid_reg || !result_stall;

    rglu_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .dstat (dstat),
        .astat (astat),
        .ctl   (ctl)
    );

    rglu_dp u_dp
    (
        .clk     (clk),
        .op      (ctl.op),
        .gcd_acc (gcd_acc_reg),
        .lcm_acc (lcm_acc_reg),
        .mag     (mag_reg),
        .result  (dp_result),
        .stat    (dstat)
    );

    // accumulator updates: a new list restarts at transfer, the engine writes back later
    always_comb
    begin
        gcd_acc_next = gcd_acc_reg;
        lcm_acc_next = lcm_acc_reg;
        ovf_next     = ovf_reg;
        mag_next     = mag_reg;
        if (take)
        begin
            mag_next = in_mag;
            if (first)
            begin
                gcd_acc_next = MAG_ZERO;
                lcm_acc_next = MAG_ONE;
                ovf_next     = 1'b0;
            end
        end
        if (ctl.wr_gcd)
            gcd_acc_next = dp_result;
        case (ctl.lcm_wr)
            LCM_ZERO:
                lcm_acc_next = MAG_ZERO;
            LCM_SAT:
                lcm_acc_next = MAG_MAX;
            LCM_MUL:
            begin
                // product beyond 63 bits saturates and sets the sticky flag
                if (dstat.mul_ovf)
                begin
                    lcm_acc_next = MAG_MAX;
                    ovf_next     = 1'b1;
                end
                else
                    lcm_acc_next = dp_result;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcd_acc_reg <= MAG_ZERO;
            lcm_acc_reg <= MAG_ONE;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            gcd_acc_reg <= gcd_acc_next;
            lcm_acc_reg <= lcm_acc_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    // result register, valid clears once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (ctl.out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            gcd_out_reg <= gcd_acc_reg;
            lcm_out_reg <= lcm_acc_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign gcd_value    = gcd_out_reg;
    assign lcm_value    = lcm_out_reg;
    assign lcm_overflow = ovf_out_reg;

endmodule
